@@ sv/rounded_rect_soft_blur_matte_core_assert.svh @@
// Assertion macros shared by the checker of the matte core.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ROUNDED_RECT_SOFT_BLUR_MATTE_CORE_ASSERT_SVH
`define ROUNDED_RECT_SOFT_BLUR_MATTE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RRSBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrsbm assertion failed");

// Next-cycle implication, disabled during reset
`define RRSBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrsbm assertion failed");

`endif

@@ sv/rrsbm_pkg.sv @@
// Package of the rounded-rectangle matte core: sizes, card record, register codes,
// state codes and the outer falloff table. No dependencies.
package rrsbm_pkg;

  localparam int MAX_CARDS = 16;
  localparam int CARD_AW   = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
  localparam int CNT_W     = $clog2(MAX_CARDS + 1);

  // Configuration register indexes
  localparam logic CFG_CARD_COUNT = 1'b0;
  localparam logic CFG_PIXEL_STEP = 1'b1;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SHADE = 1'b1;

  // Sequencer states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_CENTER = 4'd1;
  localparam logic [ST_W-1:0] ST_FETCH  = 4'd2;
  localparam logic [ST_W-1:0] ST_AXIS   = 4'd3;
  localparam logic [ST_W-1:0] ST_SQX    = 4'd4;
  localparam logic [ST_W-1:0] ST_SQY    = 4'd5;
  localparam logic [ST_W-1:0] ST_ROOT   = 4'd6;
  localparam logic [ST_W-1:0] ST_DIST   = 4'd7;
  localparam logic [ST_W-1:0] ST_RAMP   = 4'd8;
  localparam logic [ST_W-1:0] ST_G1     = 4'd9;
  localparam logic [ST_W-1:0] ST_G2     = 4'd10;
  localparam logic [ST_W-1:0] ST_G3     = 4'd11;
  localparam logic [ST_W-1:0] ST_P1     = 4'd12;
  localparam logic [ST_W-1:0] ST_P2     = 4'd13;
  localparam logic [ST_W-1:0] ST_DONE   = 4'd14;

  // Ramp index: floor(2*dp/65) as (2*dp*RECIP65) >> 20
  localparam logic [14:0] RECIP65  = 15'd16132;
  // Inner ramp: floor(v/729) as (v*RECIP729) >> 36
  localparam logic [26:0] RECIP729 = 27'd94265401;

  typedef struct packed {
    logic [7:0]         opacity;
    logic [15:0]        radius;
    logic [16:0]        h;
    logic [16:0]        w;
    logic signed [17:0] y;
    logic signed [17:0] x;
  } card_t;

  typedef logic [255:0][16:0] falloff_tab_t;

  // log2 with 20 fraction bits: normalize to Q30, then square and halve
  function automatic longint log2_q20(longint unsigned n);
    int             k;
    longint unsigned m;
    longint         res;
    k = 0;
    for (int j = 1; j <= 40; j++) begin
      if ((n >> j) != 0) k = j;
    end
    m   = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
    res = longint'(k) <<< 20;
    for (int b = 19; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m   = m >> 1;
        res = res + (longint'(1) <<< b);
      end
    end
    return res;
  endfunction

  // Largest Q16 y with 20*lg(y) <= 27*lg(1 - smoothstep(t)), per table slot
  function automatic falloff_tab_t build_falloff();
    falloff_tab_t    tab;
    longint unsigned o;
    longint unsigned s;
    longint unsigned u;
    longint unsigned y;
    longint unsigned c;
    longint          target;
    for (int i = 0; i < 256; i++) begin
      o      = 64'(2 * i + 1);
      s      = o * o * (64'd1536 - 2 * o);
      u      = (64'd1 << 27) - s;
      target = 27 * (log2_q20(u) - (longint'(27) <<< 20));
      y      = 0;
      for (int b = 16; b >= 0; b--) begin
        c = y + (64'd1 << b);
        if (c <= 64'd65536 && 20 * (log2_q20(c) - (longint'(16) <<< 20)) <= target) y = c;
      end
      tab[i] = 17'(y);
    end
    return tab;
  endfunction

  localparam falloff_tab_t FALLOFF = build_falloff();

endpackage

@@ sv/rounded_rect_soft_blur_matte_core.sv @@
// Rounded-rectangle soft blur matte: card table in a synchronous memory and a
// per-card distance, falloff and ramp sequencer. Depends on rrsbm_pkg.
//
// channel  | direction | transfer when             | payload
// ---------+-----------+---------------------------+--------------------------------
// item     | in        | start && !busy            | kind, card_*, mask_col/row
// result   | out       | alpha_valid_o (one cycle) | alpha_o
// config   | in        | cfg_valid_i && cfg_ready_o| cfg_index_i, cfg_data_i
//
// A load item writes the card memory and busy stays low.
// A shade item holds busy while, per active card, the memory read, squares,
// the 25-step square root and the ramp chain run in turn.
// The result strobe comes in the cycle in which busy falls; it cannot be stalled.
// Reset clears control and sets card_count 0, pixel_step 1024; the card memory
// holds no reset value and config is always taken.
module rounded_rect_soft_blur_matte_core
  import rrsbm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [3:0]         card_index_i,
  input  logic signed [17:0] card_x_i,
  input  logic signed [17:0] card_y_i,
  input  logic [16:0]        card_w_i,
  input  logic [16:0]        card_h_i,
  input  logic [15:0]        card_radius_i,
  input  logic [7:0]         card_opacity_i,
  input  logic [9:0]         mask_col_i,
  input  logic [9:0]         mask_row_i,
  output logic               alpha_valid_o,
  output logic [7:0]         alpha_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // Signed offset of the pixel center from the card axis, less the straight part
  function automatic logic signed [25:0] axis_off(logic [22:0] p2, logic signed [17:0] lo,
                                                  logic [16:0] size, logic [16:0] r);
    logic signed [25:0] diff;
    logic [24:0]        mag;
    diff = $signed({3'b0, p2}) - ($signed({{8{lo[17]}}, lo}) <<< 1) - $signed({9'b0, size});
    mag  = diff[25] ? 25'(-diff) : diff[24:0];
    return $signed({1'b0, mag}) - $signed({9'b0, size}) + $signed({9'b0, r});
  endfunction

  logic [ST_W-1:0]    state_q, state_d;
  logic [4:0]         count_q;
  logic [15:0]        step_q;
  logic [CNT_W-1:0]   k_q, n_q;
  logic               valid_q;
  logic [7:0]         alpha_q;

  card_t              card_mem [MAX_CARDS];
  card_t              rd_q;
  card_t              wr_card;
  logic               load_we;

  logic [9:0]         col_q, row_q;
  logic [22:0]        px2_q, py2_q;
  logic [16:0]        r_q;
  logic signed [25:0] qx_q, qy_q;
  logic [7:0]         op_q;
  logic [47:0]        sq_q;
  logic [49:0]        opnd_q;
  logic [26:0]        rem_q;
  logic [24:0]        root_q;
  logic [4:0]         it_q;
  logic signed [27:0] d_q;
  logic               ok_q;
  logic [7:0]         idx_q;
  logic [10:0]        a_q;
  logic [20:0]        a2_q;
  logic [30:0]        nprod_q;
  logic [16:0]        f_q, g_q;
  logic [33:0]        fg_q;
  logic [41:0]        best_q;

  // Combinational helpers
  logic [26:0]        px_prod, py_prod;
  logic [16:0]        r2, shorter, r_sel;
  logic signed [25:0] qx_c, qy_c, mx_c, inside_c;
  logic [23:0]        ox_c, oy_c;
  logic [47:0]        oy2_c;
  logic [28:0]        rem_t, trial;
  logic               take;
  logic [13:0]        dp_c, e_c;
  logic [29:0]        idx_mul;
  logic [16:0]        a5_c;
  logic [11:0]        t_c;
  logic [52:0]        g_mul;
  logic [41:0]        p_c;
  logic [42:0]        round_c;
  logic [CNT_W-1:0]   n_c;
  logic               accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign alpha_valid_o = valid_q;
  assign alpha_o     = alpha_q;

  assign load_we = accept && (kind_i == KIND_LOAD) && (int'(card_index_i) < MAX_CARDS);
  always_comb begin
    wr_card.opacity = card_opacity_i;
    wr_card.radius  = card_radius_i;
    wr_card.h       = card_h_i;
    wr_card.w       = card_w_i;
    wr_card.y       = card_y_i;
    wr_card.x       = card_x_i;
  end

  // Card memory: one write port for loads, one registered read at the card counter
  always_ff @(posedge clk_i) begin
    if (load_we) card_mem[CARD_AW'(card_index_i)] <= wr_card;
    rd_q <= card_mem[k_q[CARD_AW-1:0]];
  end

  // Datapath terms
  always_comb begin
    px_prod  = {6'b0, col_q, 1'b1} * {11'b0, step_q};
    py_prod  = {6'b0, row_q, 1'b1} * {11'b0, step_q};
    r2       = {rd_q.radius, 1'b0};
    shorter  = (rd_q.w < rd_q.h) ? rd_q.w : rd_q.h;
    r_sel    = (r2 > shorter) ? shorter : r2;
    qx_c     = axis_off(px2_q, rd_q.x, rd_q.w, r_sel);
    qy_c     = axis_off(py2_q, rd_q.y, rd_q.h, r_sel);
    ox_c     = (qx_q > 26'sd0) ? qx_q[23:0] : 24'd0;
    oy_c     = (qy_q > 26'sd0) ? qy_q[23:0] : 24'd0;
    oy2_c    = oy_c * oy_c;
    mx_c     = (qx_q > qy_q) ? qx_q : qy_q;
    inside_c = (mx_c > 26'sd0) ? 26'sd0 : mx_c;
    rem_t    = {rem_q, opnd_q[49:48]};
    trial    = {2'b0, root_q, 2'b01};
    take     = (rem_t >= trial);
    dp_c     = (d_q > 28'sd0) ? d_q[13:0] : 14'd0;
    e_c      = 14'(d_q + 28'sd384);
    idx_mul  = {15'b0, dp_c, 1'b0} * {15'b0, RECIP65};
    a5_c     = {3'b0, e_c} + {1'b0, e_c, 2'b0};
    t_c      = 12'd3456 - {a_q, 1'b0};
    g_mul    = {27'b0, nprod_q[30:5]} * {26'b0, RECIP729};
    p_c      = 42'(fg_q) * {34'b0, op_q};
    round_c  = {1'b0, best_q} + (43'd1 << 31);
    n_c      = (int'(count_q) > MAX_CARDS) ? CNT_W'(MAX_CARDS) : CNT_W'(count_q);
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept && kind_i == KIND_SHADE) state_d = ST_CENTER;
      ST_CENTER: state_d = (n_c == '0) ? ST_DONE : ST_FETCH;
      ST_FETCH:  state_d = ST_AXIS;
      ST_AXIS:   state_d = ST_SQX;
      ST_SQX:    state_d = ST_SQY;
      ST_SQY:    state_d = ST_ROOT;
      ST_ROOT:   if (it_q == 5'd24) state_d = ST_DIST;
      ST_DIST:   state_d = ST_RAMP;
      ST_RAMP:   state_d = ST_G1;
      ST_G1:     state_d = ST_G2;
      ST_G2:     state_d = ST_G3;
      ST_G3:     state_d = ST_P1;
      ST_P1:     state_d = ST_P2;
      ST_P2:     state_d = (k_q + 1'b1 == n_q) ? ST_DONE : ST_FETCH;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= 5'd0;
      step_q  <= 16'd1024;
      valid_q <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == ST_DONE);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CARD_COUNT: count_q <= cfg_data_i[4:0];
          CFG_PIXEL_STEP: step_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CENTER) begin
        k_q <= '0;
        n_q <= n_c;
      end else if (state_q == ST_P2) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Per-card datapath: one step per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        col_q <= mask_col_i;
        row_q <= mask_row_i;
      end
      ST_CENTER: begin
        px2_q  <= px_prod[26:4];
        py2_q  <= py_prod[26:4];
        best_q <= '0;
      end
      ST_AXIS: begin
        r_q  <= r_sel;
        qx_q <= qx_c;
        qy_q <= qy_c;
        op_q <= rd_q.opacity;
      end
      ST_SQX: sq_q <= ox_c * ox_c;
      ST_SQY: begin
        opnd_q <= {1'b0, 49'({1'b0, sq_q} + {1'b0, oy2_c})};
        rem_q  <= '0;
        root_q <= '0;
        it_q   <= '0;
      end
      ST_ROOT: begin
        rem_q  <= take ? 27'(rem_t - trial) : rem_t[26:0];
        root_q <= {root_q[23:0], take};
        opnd_q <= {opnd_q[47:0], 2'b00};
        it_q   <= it_q + 1'b1;
      end
      ST_DIST: begin
        d_q  <= $signed({3'b0, root_q}) + 28'(inside_c) - $signed({11'b0, r_q});
      end
      ST_RAMP: begin
        ok_q  <= (op_q >= 8'd3) && (d_q > -28'sd384) && (d_q < 28'sd8320);
        idx_q <= idx_mul[27:20];
        a_q   <= (a5_c > 17'd1152) ? 11'd1152 : a5_c[10:0];
      end
      ST_G1: begin
        a2_q <= {10'b0, a_q} * {10'b0, a_q};
        f_q  <= FALLOFF[idx_q];
      end
      ST_G2: nprod_q <= 31'({10'b0, a2_q} * {19'b0, t_c});
      ST_G3: g_q <= g_mul[52:36];
      ST_P1: fg_q <= f_q * g_q;
      ST_P2: if (ok_q && p_c > best_q) best_q <= p_c;
      ST_DONE: alpha_q <= (round_c[42:32] > 11'd255) ? 8'd255 : round_c[39:32];
      default: ;
    endcase
  end

endmodule

@@ sv/rrsbm_checker.sv @@
// Port-level checker for the matte core, attached by bind below.
// Depends on rounded_rect_soft_blur_matte_core_assert.svh.
`include "rounded_rect_soft_blur_matte_core_assert.svh"

module rrsbm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic kind_i,
  input logic alpha_valid_o
);

  // Shade transfer starts the card sweep
  `RRSBM_ASSERT_NXT(a_shade_busy, clk_i, rst_ni, start && !busy && kind_i, busy)
  // Load transfer completes in its own cycle, no result
  `RRSBM_ASSERT_NXT(a_load_quiet, clk_i, rst_ni, start && !busy && !kind_i,
                    !busy && !alpha_valid_o)
  // Every finished sweep delivers its result right after busy drops
  `RRSBM_ASSERT_IMP(a_done_result, clk_i, rst_ni, $fell(busy), alpha_valid_o)
  // Result strobe lasts one cycle
  `RRSBM_ASSERT_NXT(a_strobe_once, clk_i, rst_ni, alpha_valid_o, !alpha_valid_o)

endmodule

bind rounded_rect_soft_blur_matte_core rrsbm_checker u_rrsbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .kind_i        (kind_i),
  .alpha_valid_o (alpha_valid_o)
);
